@@ design/sha1he_pkg.sv @@
// Package for the SHA-1 hash engine: constants, round functions and the
// control struct between the sequencer and the message schedule.
// No dependencies.
package sha1he_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned VB_W    = 6;
    localparam int unsigned CNT_W   = 64;
    localparam int unsigned ROUND_W = 7;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned NUM_H   = 5;
    localparam int unsigned NUM_W   = 16;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(79);
    localparam logic [POS_W-1:0]   POS_LEN_HI = POS_W'(14);
    localparam logic [POS_W-1:0]   POS_FULL   = POS_W'(15);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(4);
    localparam logic [VB_W-1:0]    VB_FULL    = VB_W'(32);
    localparam logic [WORD_W-1:0]  PAD_ONE    = 32'h8000_0000;

    localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

    localparam logic [WORD_W-1:0] H0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] H1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] H2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] H3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] H4 = 32'hC3D2_E1F0;

    typedef logic [NUM_H-1:0][WORD_W-1:0] hash_vec_t;

    localparam hash_vec_t INIT_HASH = {H4, H3, H2, H1, H0};

    typedef struct packed {
        logic load;
        logic step;
    } sched_ctrl_t;

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        priority if (t <= ROUND_W'(19)) begin
            k = K0;
        end else if (t <= ROUND_W'(39)) begin
            k = K1;
        end else if (t <= ROUND_W'(59)) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] t,
                                                  input logic [WORD_W-1:0]  b,
                                                  input logic [WORD_W-1:0]  c,
                                                  input logic [WORD_W-1:0]  d);
        logic [WORD_W-1:0] f;
        priority if (t <= ROUND_W'(19)) begin
            f = (b & c) | (~b & d);
        end else if (t <= ROUND_W'(39)) begin
            f = b ^ c ^ d;
        end else if (t <= ROUND_W'(59)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

@@ design/sha1_hash_engine_unit.sv @@
// Top level of the SHA-1 hash engine: stream ports, message padding and
// the block sequencer. Depends on sha1he_pkg, sha1he_sched, sha1he_round.
//
// Computes the SHA-1 digest of a bit-granular message. Each input
// transaction is one 32-bit word, first bit in bit 31; words without tlast
// count as 32 bits, the word with tlast carries valid_bits leading bits
// (0 to 32, higher values act as 32). Words are taken one per cycle until a
// 512-bit block is full; the block then runs 80 rounds through one shared
// round unit, one round per cycle, and then updates the chaining words.
// After the last word the padding words enter one per cycle, with one or
// two further compressions, and the five digest words h0..h4 follow as five
// output transactions. s_tready is low from a full block until the chaining
// words are updated and during padding and digest output.
module sha1_hash_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // message_word[31:0], valid_bits[37:32], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                               state_reg;
    sha1he_pkg::hash_vec_t                chain_reg;
    sha1he_pkg::hash_vec_t                work_reg;
    sha1he_pkg::hash_vec_t                work_next;
    logic [sha1he_pkg::CNT_W-1:0]         cnt_reg;
    logic [sha1he_pkg::POS_W-1:0]         pos_reg;
    logic [sha1he_pkg::ROUND_W-1:0]       rnd_reg;
    logic [sha1he_pkg::IDX_W-1:0]         idx_reg;
    logic                                 finish_reg;
    logic                                 one_pend_reg;
    logic                                 hi_sent_reg;
    logic                                 done_reg;

    logic [sha1he_pkg::WORD_W-1:0]        msg_word;
    logic [sha1he_pkg::VB_W-1:0]          vb_raw;
    logic [sha1he_pkg::VB_W-1:0]          vb_sat;
    logic [sha1he_pkg::WORD_W-1:0]        keep_mask;
    logic [sha1he_pkg::WORD_W-1:0]        last_push;
    logic [sha1he_pkg::WORD_W-1:0]        pad_word;
    logic [sha1he_pkg::WORD_W-1:0]        push_word;
    logic [sha1he_pkg::WORD_W-1:0]        w_cur;
    logic                                 s_fire;
    logic                                 m_fire;
    logic                                 push;
    logic                                 block_full;
    sha1he_pkg::sched_ctrl_t              sched_ctrl;

    assign msg_word  = s_tdata[31:0];
    assign vb_raw    = s_tdata[37:32];
    assign vb_sat    = vb_raw[5] ? sha1he_pkg::VB_FULL : vb_raw;
    assign keep_mask = ~(32'hFFFF_FFFF >> vb_sat);
    assign last_push = (msg_word & keep_mask) | (sha1he_pkg::PAD_ONE >> vb_sat);

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == sha1he_pkg::IDX_LAST);

    always_comb begin
        priority if (one_pend_reg) begin
            pad_word = sha1he_pkg::PAD_ONE;
        end else if (hi_sent_reg) begin
            pad_word = cnt_reg[31:0];
        end else if (pos_reg == sha1he_pkg::POS_LEN_HI) begin
            pad_word = cnt_reg[63:32];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        push      = 1'b0;
        push_word = pad_word;
        unique case (state_reg)
            ST_LOAD: begin
                push      = s_fire;
                push_word = (!s_tlast || vb_sat == sha1he_pkg::VB_FULL) ? msg_word
                                                                      : last_push;
            end
            ST_PAD: begin
                push = 1'b1;
            end
            ST_ROUND, ST_ADD, ST_OUT: begin
                push = 1'b0;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign block_full      = push && (pos_reg == sha1he_pkg::POS_FULL);
    assign sched_ctrl.load = push;
    assign sched_ctrl.step = (state_reg == ST_ROUND);

    sha1he_sched u_sched (
        .aclk      (aclk),
        .ctrl      (sched_ctrl),
        .load_word (push_word),
        .w_cur     (w_cur)
    );

    sha1he_round u_round (
        .work_in   (work_reg),
        .w_cur     (w_cur),
        .round_idx (rnd_reg),
        .work_out  (work_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            chain_reg    <= sha1he_pkg::INIT_HASH;
            work_reg     <= '0;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            rnd_reg      <= '0;
            idx_reg      <= '0;
            finish_reg   <= 1'b0;
            one_pend_reg <= 1'b0;
            hi_sent_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            if (push) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (block_full) begin
                work_reg <= chain_reg;
                rnd_reg  <= '0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (!s_tlast) begin
                            cnt_reg <= cnt_reg + sha1he_pkg::CNT_W'(32);
                        end else begin
                            cnt_reg      <= cnt_reg + sha1he_pkg::CNT_W'(vb_sat);
                            finish_reg   <= 1'b1;
                            one_pend_reg <= (vb_sat == sha1he_pkg::VB_FULL);
                        end
                        if (block_full) begin
                            state_reg <= ST_ROUND;
                        end else if (s_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    priority if (one_pend_reg) begin
                        one_pend_reg <= 1'b0;
                    end else if (hi_sent_reg) begin
                        done_reg <= 1'b1;
                    end else if (pos_reg == sha1he_pkg::POS_LEN_HI) begin
                        hi_sent_reg <= 1'b1;
                    end else begin
                        done_reg <= done_reg;
                    end
                    if (block_full) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    work_reg <= work_next;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == sha1he_pkg::LAST_ROUND) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    rnd_reg <= '0;
                    for (int i = 0; i < sha1he_pkg::NUM_H; i++) begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    priority if (!finish_reg) begin
                        state_reg <= ST_LOAD;
                    end else if (done_reg) begin
                        idx_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT: begin
                    if (m_fire) begin
                        if (idx_reg == sha1he_pkg::IDX_LAST) begin
                            state_reg    <= ST_LOAD;
                            chain_reg    <= sha1he_pkg::INIT_HASH;
                            work_reg     <= '0;
                            cnt_reg      <= '0;
                            pos_reg      <= '0;
                            idx_reg      <= '0;
                            finish_reg   <= 1'b0;
                            one_pend_reg <= 1'b0;
                            hi_sent_reg  <= 1'b0;
                            done_reg     <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

@@ design/sha1he_sched.sv @@
// Message schedule window of the SHA-1 hash engine: 16-word shift line that
// loads message words and expands the schedule one word per round.
// Depends on sha1he_pkg.
module sha1he_sched (
    input  logic                           aclk,
    input  sha1he_pkg::sched_ctrl_t        ctrl,
    input  logic [sha1he_pkg::WORD_W-1:0]  load_word,
    output logic [sha1he_pkg::WORD_W-1:0]  w_cur
);

    logic [sha1he_pkg::WORD_W-1:0] w_reg [sha1he_pkg::NUM_W];
    logic [sha1he_pkg::WORD_W-1:0] mix;
    logic [sha1he_pkg::WORD_W-1:0] expand;

    assign mix    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign expand = {mix[30:0], mix[31]};
    assign w_cur  = w_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.load || ctrl.step) begin
            for (int i = 0; i < sha1he_pkg::NUM_W - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha1he_pkg::NUM_W-1] <= ctrl.load ? load_word : expand;
        end
    end

endmodule

@@ design/sha1he_round.sv @@
// SHA-1 round unit: one compression round on the working words a..e.
// Shared by all 80 rounds. Depends on sha1he_pkg.
module sha1he_round (
    input  sha1he_pkg::hash_vec_t                work_in,
    input  logic [sha1he_pkg::WORD_W-1:0]        w_cur,
    input  logic [sha1he_pkg::ROUND_W-1:0]       round_idx,
    output sha1he_pkg::hash_vec_t                work_out
);

    logic [sha1he_pkg::WORD_W-1:0] a, b, c, d, e;
    logic [sha1he_pkg::WORD_W-1:0] tmp;

    assign a = work_in[0];
    assign b = work_in[1];
    assign c = work_in[2];
    assign d = work_in[3];
    assign e = work_in[4];

    assign tmp = {a[26:0], a[31:27]} + sha1he_pkg::round_f(round_idx, b, c, d)
                 + e + w_cur + sha1he_pkg::round_k(round_idx);

    assign work_out[0] = tmp;
    assign work_out[1] = a;
    assign work_out[2] = {b[1:0], b[31:2]};
    assign work_out[3] = c;
    assign work_out[4] = d;

endmodule
